// ===== hw/rtl/gzd_pkg.sv =====
// Shared types and constants for the gzip member deframer.
package gzd_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        item_kind;
      logic [7:0]  payload_byte;
      logic [2:0]  status;
      logic [31:0] trailer_crc;
      logic [31:0] trailer_size;
      logic        run_end;
   } rsp_type;

   // Up to two results produced by one input byte, payload before summary.
   typedef struct packed {
      logic    pay_valid;
      rsp_type pay;
      logic    sum_valid;
      rsp_type sum;
   } push_type;

   typedef enum logic [12:0] {
      PH_ID1     = 13'b0_0000_0000_0001,
      PH_ID2     = 13'b0_0000_0000_0010,
      PH_CM      = 13'b0_0000_0000_0100,
      PH_FLG     = 13'b0_0000_0000_1000,
      PH_FIXED   = 13'b0_0000_0001_0000,
      PH_XLEN_LO = 13'b0_0000_0010_0000,
      PH_XLEN_HI = 13'b0_0000_0100_0000,
      PH_EXTRA   = 13'b0_0000_1000_0000,
      PH_NAME    = 13'b0_0001_0000_0000,
      PH_COMMENT = 13'b0_0010_0000_0000,
      PH_HCRC    = 13'b0_0100_0000_0000,
      PH_PAYLOAD = 13'b0_1000_0000_0000,
      PH_DRAIN   = 13'b1_0000_0000_0000
   } phase_type;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [2:0] ST_OK            = 3'd0;
   localparam logic [2:0] ST_TOO_SHORT     = 3'd1;
   localparam logic [2:0] ST_BAD_MAGIC     = 3'd2;
   localparam logic [2:0] ST_BAD_METHOD    = 3'd3;
   localparam logic [2:0] ST_TRUNC_HEADER  = 3'd4;
   localparam logic [2:0] ST_EXTRA_OVERRUN = 3'd5;
   localparam logic [2:0] ST_NO_DATA       = 3'd6;
   localparam logic [2:0] ST_NO_TRAILER    = 3'd7;

   localparam logic [7:0] MAGIC_ID1  = 8'h1f;
   localparam logic [7:0] MAGIC_ID2  = 8'h8b;
   localparam logic [7:0] CM_DEFLATE = 8'd8;

   localparam int FLG_HCRC    = 1;
   localparam int FLG_EXTRA   = 2;
   localparam int FLG_NAME    = 3;
   localparam int FLG_COMMENT = 4;

   localparam logic [4:0] MIN_MEMBER = 5'd18;
   localparam int         HOLD_DEPTH = 8;

   localparam int RSP_FIFO_DEPTH = 8;

endpackage

// ===== hw/rtl/gzd_parse.sv =====
// Header/trailer state machine and 8-byte holdback line.
module gzd_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_valid,
   input  gzd_pkg::req_type  step_req,
   output gzd_pkg::push_type push
);

   gzd_pkg::phase_type phase_ff, phase_in;
   logic [4:0]  count_ff, count_in;
   logic [7:0]  flags_ff, flags_in;
   logic [15:0] skip_ff, skip_in;
   logic [7:0]  xlen_ff, xlen_in;
   logic [3:0]  fill_ff, fill_in;
   logic [2:0]  err_ff, err_in;
   logic [7:0]  line_ff [gzd_pkg::HOLD_DEPTH];
   logic [7:0]  line_in [gzd_pkg::HOLD_DEPTH];
   logic [7:0]  b;
   logic [2:0]  st;

   // First optional section at or after stage: 0 extra, 1 name, 2 comment, 3 hcrc.
   function automatic gzd_pkg::phase_type enter_stage(input logic [2:0] stage,
                                                      input logic [7:0] flags);
      gzd_pkg::phase_type ph;
      if (stage == 3'd0 && flags[gzd_pkg::FLG_EXTRA])
         ph = gzd_pkg::PH_XLEN_LO;
      else if (stage <= 3'd1 && flags[gzd_pkg::FLG_NAME])
         ph = gzd_pkg::PH_NAME;
      else if (stage <= 3'd2 && flags[gzd_pkg::FLG_COMMENT])
         ph = gzd_pkg::PH_COMMENT;
      else if (stage <= 3'd3 && flags[gzd_pkg::FLG_HCRC])
         ph = gzd_pkg::PH_HCRC;
      else
         ph = gzd_pkg::PH_PAYLOAD;
      return ph;
   endfunction

   assign b = step_req.data_byte;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      flags_in = flags_ff;
      skip_in  = skip_ff;
      xlen_in  = xlen_ff;
      fill_in  = fill_ff;
      err_in   = err_ff;
      line_in  = line_ff;
      st       = gzd_pkg::ST_OK;
      push     = '0;

      if (step_valid) begin
         if (count_ff < gzd_pkg::MIN_MEMBER) count_in = count_ff + 5'd1;

         case (phase_ff)
            gzd_pkg::PH_ID1: begin
               if (b == gzd_pkg::MAGIC_ID1) phase_in = gzd_pkg::PH_ID2;
               else begin
                  err_in   = gzd_pkg::ST_BAD_MAGIC;
                  phase_in = gzd_pkg::PH_DRAIN;
               end
            end
            gzd_pkg::PH_ID2: begin
               if (b == gzd_pkg::MAGIC_ID2) phase_in = gzd_pkg::PH_CM;
               else begin
                  err_in   = gzd_pkg::ST_BAD_MAGIC;
                  phase_in = gzd_pkg::PH_DRAIN;
               end
            end
            gzd_pkg::PH_CM: begin
               if (b == gzd_pkg::CM_DEFLATE) phase_in = gzd_pkg::PH_FLG;
               else begin
                  err_in   = gzd_pkg::ST_BAD_METHOD;
                  phase_in = gzd_pkg::PH_DRAIN;
               end
            end
            gzd_pkg::PH_FLG: begin
               flags_in = b;
               skip_in  = 16'd6;
               phase_in = gzd_pkg::PH_FIXED;
            end
            gzd_pkg::PH_FIXED: begin
               skip_in = skip_ff - 16'd1;
               if (skip_in == 16'd0) phase_in = enter_stage(3'd0, flags_ff);
            end
            gzd_pkg::PH_XLEN_LO: begin
               xlen_in  = b;
               phase_in = gzd_pkg::PH_XLEN_HI;
            end
            gzd_pkg::PH_XLEN_HI: begin
               skip_in = {b, xlen_ff};
               if (skip_in == 16'd0) phase_in = enter_stage(3'd1, flags_ff);
               else phase_in = gzd_pkg::PH_EXTRA;
            end
            gzd_pkg::PH_EXTRA: begin
               skip_in = skip_ff - 16'd1;
               if (skip_in == 16'd0) phase_in = enter_stage(3'd1, flags_ff);
            end
            gzd_pkg::PH_NAME: begin
               if (b == 8'd0) phase_in = enter_stage(3'd2, flags_ff);
            end
            gzd_pkg::PH_COMMENT: begin
               if (b == 8'd0) phase_in = enter_stage(3'd3, flags_ff);
            end
            gzd_pkg::PH_HCRC: begin
               skip_in = skip_ff - 16'd1;
               if (skip_in == 16'd0) phase_in = gzd_pkg::PH_PAYLOAD;
            end
            gzd_pkg::PH_PAYLOAD: begin
               if (fill_ff[3]) begin
                  // line full: oldest byte leaves as payload
                  push.pay_valid        = 1'b1;
                  push.pay.item_kind    = gzd_pkg::KIND_PAYLOAD;
                  push.pay.payload_byte = line_ff[0];
                  push.pay.run_end      = !step_req.last_byte;
                  for (int i = 0; i < gzd_pkg::HOLD_DEPTH - 1; i++)
                     line_in[i] = line_ff[i+1];
                  line_in[gzd_pkg::HOLD_DEPTH-1] = b;
               end else begin
                  line_in[fill_ff[2:0]] = b;
                  fill_in               = fill_ff + 4'd1;
               end
            end
            default: begin
            end
         endcase

         // entering the hcrc section always starts a two-byte skip
         if (phase_in == gzd_pkg::PH_HCRC && phase_ff != gzd_pkg::PH_HCRC)
            skip_in = 16'd2;

         if (step_req.last_byte) begin
            if (count_in < gzd_pkg::MIN_MEMBER) st = gzd_pkg::ST_TOO_SHORT;
            else if (err_in != gzd_pkg::ST_OK) st = err_in;
            else begin
               case (phase_in)
                  gzd_pkg::PH_EXTRA:   st = gzd_pkg::ST_EXTRA_OVERRUN;
                  gzd_pkg::PH_HCRC:    st = gzd_pkg::ST_NO_DATA;
                  gzd_pkg::PH_PAYLOAD: begin
                     if (fill_in == 4'd0) st = gzd_pkg::ST_NO_DATA;
                     else if (!fill_in[3]) st = gzd_pkg::ST_NO_TRAILER;
                     else st = gzd_pkg::ST_OK;
                  end
                  default:             st = gzd_pkg::ST_TRUNC_HEADER;
               endcase
            end
            push.sum_valid     = 1'b1;
            push.sum.item_kind = gzd_pkg::KIND_SUMMARY;
            push.sum.status    = st;
            push.sum.run_end   = 1'b1;
            if (st == gzd_pkg::ST_OK) begin
               push.sum.trailer_crc  = {line_in[3], line_in[2], line_in[1], line_in[0]};
               push.sum.trailer_size = {line_in[7], line_in[6], line_in[5], line_in[4]};
            end
            // back to reset state for the next member
            phase_in = gzd_pkg::PH_ID1;
            count_in = 5'd0;
            flags_in = 8'd0;
            skip_in  = 16'd0;
            xlen_in  = 8'd0;
            fill_in  = 4'd0;
            err_in   = gzd_pkg::ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= gzd_pkg::PH_ID1;
         count_ff <= 5'd0;
         flags_ff <= 8'd0;
         skip_ff  <= 16'd0;
         xlen_ff  <= 8'd0;
         fill_ff  <= 4'd0;
         err_ff   <= gzd_pkg::ST_OK;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         flags_ff <= flags_in;
         skip_ff  <= skip_in;
         xlen_ff  <= xlen_in;
         fill_ff  <= fill_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
   end

`ifndef SYNTHESIS
   a_reset_after_last: assert property (@(posedge clock) disable iff (reset)
      step_valid && step_req.last_byte |=>
         phase_ff == gzd_pkg::PH_ID1 && count_ff == 5'd0 && fill_ff == 4'd0)
      else $error("state not cleared after end of member");

   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      count_ff <= gzd_pkg::MIN_MEMBER)
      else $error("byte count above saturation");

   a_pay_full_line: assert property (@(posedge clock) disable iff (reset)
      push.pay_valid |-> phase_ff == gzd_pkg::PH_PAYLOAD && fill_ff == 4'd8)
      else $error("payload emitted without full holdback line");

   a_error_drains: assert property (@(posedge clock) disable iff (reset)
      err_ff != gzd_pkg::ST_OK |-> phase_ff == gzd_pkg::PH_DRAIN)
      else $error("latched error outside drain phase");
`endif

endmodule

// ===== hw/rtl/gzd_rsp_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one while rsp_stall is low.
module gzd_rsp_fifo #(
   parameter int unsigned DEPTH = gzd_pkg::RSP_FIFO_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  gzd_pkg::push_type            push,
   output logic [$clog2(DEPTH):0]       level,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output gzd_pkg::rsp_type             rsp_data
);

   localparam int AW = $clog2(DEPTH);

   gzd_pkg::rsp_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;
   logic [1:0]    push_n;
   logic          pop;
   gzd_pkg::rsp_type first;

   assign push_n    = {1'b0, push.pay_valid} + {1'b0, push.sum_valid};
   assign first     = push.pay_valid ? push.pay : push.sum;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign level     = count_ff;

   assign wr_ptr_in = wr_ptr_ff + AW'(push_n);
   assign rd_ptr_in = rd_ptr_ff + AW'(pop);
   assign count_in  = count_ff + (AW+1)'(push_n) - (AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) mem_ff[wr_ptr_ff] <= first;
      if (push.pay_valid && push.sum_valid) mem_ff[wr_ptr_ff + AW'(1)] <= push.sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (AW+2)'(count_ff) + (AW+2)'(push_n) <= (AW+2)'(DEPTH) + (AW+2)'(pop))
      else $error("result queue overflow");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      AW'(wr_ptr_ff - rd_ptr_ff) == count_ff[AW-1:0])
      else $error("queue pointers disagree with count");
`endif

endmodule

// ===== hw/rtl/gzip_member_deframer_core.sv =====
// Top level of the gzip member deframer.
//
// Input channel req_*: one byte of a gzip member per transaction, with
// last_byte set on the member's final byte. Result channel rsp_*: payload
// bytes (item_kind 0) and one end-of-member summary (item_kind 1) carrying
// status, trailer CRC-32 and ISIZE. run_end marks the last result caused by
// an input byte.
// A result passes the input register and is written into the result queue
// before it becomes valid; when the final byte also pushes out a payload byte,
// the summary is queued directly behind it.
// Throughput: one byte per cycle while req_stall is low. The byte is registered,
// parsed and its results written into a RSP_DEPTH-entry queue; req_stall rises when
// the queue could not take two more results for the byte in flight and the new
// one.
// Reset clears the parser to "expect first magic byte" and empties the queue.
// While rsp_stall is held the queue fills and then req_stall is raised; no
// result is lost or repeated.
module gzip_member_deframer_core #(
   parameter int unsigned RSP_DEPTH = gzd_pkg::RSP_FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gzd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gzd_pkg::rsp_type rsp_data
);

   localparam int LW = $clog2(RSP_DEPTH);

   logic             in_valid_ff, in_valid_in;
   gzd_pkg::req_type in_req_ff;
   gzd_pkg::push_type push;
   logic [LW:0]      level;
   logic [LW+1:0]    need;

   // worst case: byte in flight and new byte each push two results
   assign need = (LW+2)'(level) + (in_valid_ff ? (LW+2)'(4) : (LW+2)'(2));
   assign req_stall = need > (LW+2)'(RSP_DEPTH);
   assign in_valid_in = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (in_valid_in) in_req_ff <= req_data;
   end

   gzd_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step_valid (in_valid_ff),
      .step_req   (in_req_ff),
      .push       (push)
   );

   gzd_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .level     (level),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/gzd_stream_checker.sv =====
// Checker for the gzip member deframer: predicts results per byte and compares.
module gzd_stream_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  gzd_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  gzd_pkg::rsp_type rsp_data,
   output int               mismatches,
   output int               pending,
   output int               payload_count,
   output int               summary_count,
   output logic [7:0]       status_seen
);

   // order of the optional header sections
   localparam int SEC_EXTRA   = 0;
   localparam int SEC_NAME    = 1;
   localparam int SEC_COMMENT = 2;
   localparam int SEC_HCRC    = 3;
   localparam int SEC_PAYLOAD = 4;

   gzd_pkg::phase_type ph;
   logic [4:0] seen_cnt;
   logic [7:0] flg;
   logic [15:0] skip_cnt;
   logic [7:0] xlen_lo;
   logic [7:0] hold [gzd_pkg::HOLD_DEPTH];
   logic [3:0] fill;
   logic [2:0] err;

   gzd_pkg::rsp_type expected_results [$];
   int         mismatch_total = 0;
   int         payload_total = 0;
   int         summary_total = 0;
   logic [7:0] status_mask = '0;

   task automatic clear_member();
      ph       = gzd_pkg::PH_ID1;
      seen_cnt = '0;
      flg      = '0;
      skip_cnt = '0;
      xlen_lo  = '0;
      fill     = '0;
      err      = gzd_pkg::ST_OK;
      for (int k = 0; k < gzd_pkg::HOLD_DEPTH; k++) hold[k] = '0;
   endtask

   task automatic enter_section(input int from);
      if (from <= SEC_EXTRA && flg[gzd_pkg::FLG_EXTRA]) ph = gzd_pkg::PH_XLEN_LO;
      else if (from <= SEC_NAME && flg[gzd_pkg::FLG_NAME]) ph = gzd_pkg::PH_NAME;
      else if (from <= SEC_COMMENT && flg[gzd_pkg::FLG_COMMENT]) ph = gzd_pkg::PH_COMMENT;
      else if (from <= SEC_HCRC && flg[gzd_pkg::FLG_HCRC]) begin
         ph       = gzd_pkg::PH_HCRC;
         skip_cnt = 16'd2;
      end else ph = gzd_pkg::PH_PAYLOAD;
   endtask

   function automatic logic [2:0] member_status();
      if (seen_cnt < gzd_pkg::MIN_MEMBER) return gzd_pkg::ST_TOO_SHORT;
      if (err != gzd_pkg::ST_OK) return err;
      case (ph)
         gzd_pkg::PH_EXTRA:   return gzd_pkg::ST_EXTRA_OVERRUN;
         gzd_pkg::PH_HCRC:    return gzd_pkg::ST_NO_DATA;
         gzd_pkg::PH_PAYLOAD: begin
            if (fill == 4'd0) return gzd_pkg::ST_NO_DATA;
            if (fill < gzd_pkg::HOLD_DEPTH) return gzd_pkg::ST_NO_TRAILER;
            return gzd_pkg::ST_OK;
         end
         default:             return gzd_pkg::ST_TRUNC_HEADER;
      endcase
   endfunction

   task automatic deframe_byte(input logic [7:0] b, input logic lst);
      gzd_pkg::rsp_type item;
      logic [2:0] st;
      if (seen_cnt < gzd_pkg::MIN_MEMBER) seen_cnt = seen_cnt + 5'd1;
      case (ph)
         gzd_pkg::PH_ID1: begin
            if (b == gzd_pkg::MAGIC_ID1) ph = gzd_pkg::PH_ID2;
            else begin err = gzd_pkg::ST_BAD_MAGIC; ph = gzd_pkg::PH_DRAIN; end
         end
         gzd_pkg::PH_ID2: begin
            if (b == gzd_pkg::MAGIC_ID2) ph = gzd_pkg::PH_CM;
            else begin err = gzd_pkg::ST_BAD_MAGIC; ph = gzd_pkg::PH_DRAIN; end
         end
         gzd_pkg::PH_CM: begin
            if (b == gzd_pkg::CM_DEFLATE) ph = gzd_pkg::PH_FLG;
            else begin err = gzd_pkg::ST_BAD_METHOD; ph = gzd_pkg::PH_DRAIN; end
         end
         gzd_pkg::PH_FLG: begin
            flg      = b;
            skip_cnt = 16'd6;  // MTIME, XFL, OS
            ph       = gzd_pkg::PH_FIXED;
         end
         gzd_pkg::PH_FIXED: begin
            skip_cnt = skip_cnt - 16'd1;
            if (skip_cnt == 16'd0) enter_section(SEC_EXTRA);
         end
         gzd_pkg::PH_XLEN_LO: begin
            xlen_lo = b;
            ph      = gzd_pkg::PH_XLEN_HI;
         end
         gzd_pkg::PH_XLEN_HI: begin
            skip_cnt = {b, xlen_lo};
            if (skip_cnt == 16'd0) enter_section(SEC_NAME);
            else ph = gzd_pkg::PH_EXTRA;
         end
         gzd_pkg::PH_EXTRA: begin
            skip_cnt = skip_cnt - 16'd1;
            if (skip_cnt == 16'd0) enter_section(SEC_NAME);
         end
         gzd_pkg::PH_NAME:    if (b == 8'd0) enter_section(SEC_COMMENT);
         gzd_pkg::PH_COMMENT: if (b == 8'd0) enter_section(SEC_HCRC);
         gzd_pkg::PH_HCRC: begin
            skip_cnt = skip_cnt - 16'd1;
            if (skip_cnt == 16'd0) enter_section(SEC_PAYLOAD);
         end
         gzd_pkg::PH_PAYLOAD: begin
            if (fill >= gzd_pkg::HOLD_DEPTH) begin
               // oldest held byte is now known not to be trailer
               item              = '0;
               item.item_kind    = gzd_pkg::KIND_PAYLOAD;
               item.payload_byte = hold[0];
               item.run_end      = !lst;
               expected_results.push_back(item);
               for (int k = 0; k < gzd_pkg::HOLD_DEPTH - 1; k++) hold[k] = hold[k + 1];
               hold[gzd_pkg::HOLD_DEPTH - 1] = b;
            end else begin
               hold[fill[2:0]] = b;
               fill = fill + 4'd1;
            end
         end
         default: ;
      endcase
      if (lst) begin
         st             = member_status();
         item           = '0;
         item.item_kind = gzd_pkg::KIND_SUMMARY;
         item.status    = st;
         item.run_end   = 1'b1;
         if (st == gzd_pkg::ST_OK) begin
            item.trailer_crc  = {hold[3], hold[2], hold[1], hold[0]};
            item.trailer_size = {hold[7], hold[6], hold[5], hold[4]};
         end
         expected_results.push_back(item);
         clear_member();
      end
   endtask

   task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_total++;
   endtask

   task automatic check_result(input gzd_pkg::rsp_type got);
      gzd_pkg::rsp_type want;
      if (expected_results.size() == 0) begin
         $error("unexpected result transaction %h", got);
         mismatch_total++;
         return;
      end
      want = expected_results.pop_front();
      if (got.item_kind !== want.item_kind)
         flag_field("item_kind", 32'(want.item_kind), 32'(got.item_kind));
      if (got.payload_byte !== want.payload_byte)
         flag_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
      if (got.status !== want.status)
         flag_field("status", 32'(want.status), 32'(got.status));
      if (got.trailer_crc !== want.trailer_crc)
         flag_field("trailer_crc", want.trailer_crc, got.trailer_crc);
      if (got.trailer_size !== want.trailer_size)
         flag_field("trailer_size", want.trailer_size, got.trailer_size);
      if (got.run_end !== want.run_end)
         flag_field("run_end", 32'(want.run_end), 32'(got.run_end));
      if (want.item_kind == gzd_pkg::KIND_SUMMARY) begin
         summary_total++;
         status_mask[want.status] = 1'b1;
      end else payload_total++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_member();
         expected_results.delete();
      end else begin
         if (req_valid && !req_stall) deframe_byte(req_data.data_byte, req_data.last_byte);
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
      end
      pending       <= expected_results.size();
      mismatches    <= mismatch_total;
      payload_count <= payload_total;
      summary_count <= summary_total;
      status_seen   <= status_mask;
   end

endmodule

// ===== test/tb.sv =====
// Testbench top for the gzip member deframer: stimulus, pacing and verdict.
module tb;

   typedef enum int {PACE_FREE, PACE_LIGHT, PACE_HEAVY, PACE_TOGGLE, PACE_HOLD} pace_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   gzd_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   gzd_pkg::rsp_type rsp_data;

   int         mismatches;
   int         pending;
   int         payload_count;
   int         summary_count;
   logic [7:0] status_seen;

   logic [7:0] frame [$];
   int         burst_left = 0;
   int         members_sent = 0;
   int         bytes_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   gzip_member_deframer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   gzd_stream_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .mismatches    (mismatches),
      .pending       (pending),
      .payload_count (payload_count),
      .summary_count (summary_count),
      .status_seen   (status_seen)
   );

   // one byte transaction; between bursts the sender sometimes idles
   task automatic send_byte(input logic [7:0] b, input logic lst);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, last_byte: lst};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   task automatic send_member();
      for (int k = 0; k < frame.size(); k++) send_byte(frame[k], k == frame.size() - 1);
      members_sent++;
      bytes_sent += frame.size();
   endtask

   task automatic build_good_member(input int pay_len);
      logic [7:0] flags;
      int xlen;
      frame.delete();
      flags = 8'($urandom_range(0, 255));
      frame.push_back(gzd_pkg::MAGIC_ID1);
      frame.push_back(gzd_pkg::MAGIC_ID2);
      frame.push_back(gzd_pkg::CM_DEFLATE);
      frame.push_back(flags);
      repeat (6) frame.push_back(8'($urandom_range(0, 255)));
      if (flags[gzd_pkg::FLG_EXTRA]) begin
         xlen = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 320) : $urandom_range(0, 6);
         frame.push_back(xlen[7:0]);
         frame.push_back(xlen[15:8]);
         repeat (xlen) frame.push_back(8'($urandom_range(0, 255)));
      end
      if (flags[gzd_pkg::FLG_NAME]) begin
         repeat ($urandom_range(0, 5)) frame.push_back(8'($urandom_range(1, 255)));
         frame.push_back(8'h00);
      end
      if (flags[gzd_pkg::FLG_COMMENT]) begin
         repeat ($urandom_range(0, 5)) frame.push_back(8'($urandom_range(1, 255)));
         frame.push_back(8'h00);
      end
      if (flags[gzd_pkg::FLG_HCRC]) repeat (2) frame.push_back(8'($urandom_range(0, 255)));
      repeat (pay_len + 8) frame.push_back(8'($urandom_range(0, 255)));
   endtask

   initial begin : rsp_pacing
      pace_type mode;
      int span;
      wait (!reset);
      repeat (150) begin
         @(posedge clock);
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
      // long hold-off: result queue fills and the input side must stall
      repeat (160) begin
         @(posedge clock);
         rsp_stall <= 1'b1;
      end
      forever begin
         mode = pace_type'($urandom_range(0, 4));
         span = $urandom_range(10, 100);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               PACE_FREE:   rsp_stall <= 1'b0;
               PACE_LIGHT:  rsp_stall <= ($urandom_range(0, 3) == 0);
               PACE_HEAVY:  rsp_stall <= ($urandom_range(0, 9) < 7);
               PACE_TOGGLE: rsp_stall <= ~rsp_stall;
               default:     rsp_stall <= 1'b1;
            endcase
         end
      end
   end

   initial begin : stimulus
      int pick;
      int cut;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: one-byte member, minimal empty-payload member, short bad method
      frame = '{8'hff};
      send_member();
      frame = '{gzd_pkg::MAGIC_ID1, gzd_pkg::MAGIC_ID2, gzd_pkg::CM_DEFLATE, 8'h00,
                8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00};
      send_member();
      frame = '{gzd_pkg::MAGIC_ID1, gzd_pkg::MAGIC_ID2, 8'h07, 8'h00};
      send_member();

      while (bytes_sent < 950) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            build_good_member(($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                           : $urandom_range(0, 16));
         end else if (pick < 68) begin
            build_good_member($urandom_range(0, 8));
            cut = $urandom_range(0, 1);
            frame[cut] = frame[cut] ^ 8'($urandom_range(1, 255));
         end else if (pick < 75) begin
            build_good_member($urandom_range(0, 8));
            frame[2] = 8'($urandom_range(0, 255));
            if (frame[2] == gzd_pkg::CM_DEFLATE) frame[2] = ~gzd_pkg::CM_DEFLATE;
         end else if (pick < 87) begin
            build_good_member($urandom_range(0, 8));
            cut = $urandom_range(1, frame.size() - 1);
            while (frame.size() > cut) void'(frame.pop_back());
         end else if (pick < 95) begin
            // trailer cut short, down to nothing after the header
            build_good_member($urandom_range(0, 2));
            repeat ($urandom_range(1, 8)) void'(frame.pop_back());
         end else begin
            frame.delete();
            repeat ($urandom_range(1, 24)) frame.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 1) frame[0] = gzd_pkg::MAGIC_ID1;
         end
         send_member();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d members in %0d bytes; checked %0d payload bytes and %0d summaries.",
               members_sent, bytes_sent, payload_count, summary_count);
      $display("Summary status codes seen (bit per code): %b", status_seen);
      if (mismatches == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : watchdog
      #1000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
